>>> rtl/core/lkv_pkg.sv
// lkv_pkg: shared types and constants of the look-at view matrix block
// no dependencies; imported by the channel interfaces, lkv_norm and the top level
package lkv_pkg;

    // axis components, Q2.14
    localparam int AXIS_W   = 16;
    localparam int AXIS_ONE = 16384;

    // positions and translations, Q16.16
    localparam int POS_W = 32;

    // configuration register map
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_UP_X = 2'd0,
        CFG_UP_Y = 2'd1,
        CFG_UP_Z = 2'd2
    } t_cfg_reg;

    // up vector after reset
    localparam logic [CFG_DATA_W-1:0] UP_X_RST = 16'sd0;
    localparam logic [CFG_DATA_W-1:0] UP_Y_RST = 16'sd16384;
    localparam logic [CFG_DATA_W-1:0] UP_Z_RST = 16'sd0;

    // normaliser: magnitudes are brought into [2^(NRM_W-1), 2^NRM_W)
    localparam int NRM_W      = 30;
    localparam int NRM_SH_ST  = 5;    // shift decisions 16, 8, 4, 2, 1
    localparam int ROOT_W     = 64;
    localparam int ROOT_TOP   = 62;   // first trial bit of the square root
    localparam int ROOT_STEPS = 32;
    localparam int LEN_W      = 32;
    localparam int DIV_W      = 48;
    localparam int QUO_W      = 15;
    localparam int FRAC_SH    = 15;   // numerator scale, one bit above Q2.14

    // translation rounding
    localparam int DOT_W    = 50;
    localparam int RND_SH   = 14;
    localparam int RND_HALF = 8192;

    typedef logic [2:0][AXIS_W-1:0] t_axis;
    typedef logic [2:0][POS_W-1:0]  t_pos;

endpackage

>>> rtl/core/lkv_ifs.sv
// lkv_ifs: valid/ready channels of the look-at view matrix block
// depends on lkv_pkg for the field widths
interface lkv_in_if import lkv_pkg::*;;
    logic                    valid;
    logic                    ready;
    logic signed [POS_W-1:0] eye_x;
    logic signed [POS_W-1:0] eye_y;
    logic signed [POS_W-1:0] eye_z;
    logic signed [POS_W-1:0] aim_x;
    logic signed [POS_W-1:0] aim_y;
    logic signed [POS_W-1:0] aim_z;

    modport source (output valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, input ready);
    modport sink   (input valid, eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, output ready);
endinterface

interface lkv_out_if import lkv_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic signed [AXIS_W-1:0] row0_x;
    logic signed [AXIS_W-1:0] row0_y;
    logic signed [AXIS_W-1:0] row0_z;
    logic signed [POS_W-1:0]  row0_shift;
    logic signed [AXIS_W-1:0] row1_x;
    logic signed [AXIS_W-1:0] row1_y;
    logic signed [AXIS_W-1:0] row1_z;
    logic signed [POS_W-1:0]  row1_shift;
    logic signed [AXIS_W-1:0] row2_x;
    logic signed [AXIS_W-1:0] row2_y;
    logic signed [AXIS_W-1:0] row2_z;
    logic signed [POS_W-1:0]  row2_shift;

    modport source (output valid, row0_x, row0_y, row0_z, row0_shift,
                    row1_x, row1_y, row1_z, row1_shift,
                    row2_x, row2_y, row2_z, row2_shift, input ready);
    modport sink   (input valid, row0_x, row0_y, row0_z, row0_shift,
                    row1_x, row1_y, row1_z, row1_shift,
                    row2_x, row2_y, row2_z, row2_shift, output ready);
endinterface

interface lkv_cfg_if import lkv_pkg::*;;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/core/look_at_view_matrix.sv
// look_at_view_matrix: accepts one beat per cycle while the output is not stalled.
// the pipe is three normalisers in series, each 57 stages deep, mostly the
// 32-step square root and the 15-step divider, plus six registers of the top level;
// a stall at the output freezes every stage.
// reset clears all valid bits and sets the up vector to (0, 1, 0) in Q2.14.
// depends on lkv_pkg, the channel interfaces in lkv_ifs and lkv_norm
module look_at_view_matrix import lkv_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lkv_in_if.sink    i_in,
    lkv_cfg_if.sink   i_cfg,
    lkv_out_if.source o_out
);

    localparam int DIFF_W  = POS_W + 1;
    localparam int PROD_W  = 2 * AXIS_W;
    localparam int CROSS_W = PROD_W + 1;
    localparam int DP_W    = AXIS_W + POS_W;
    localparam int SAT_W   = DOT_W - POS_W + 1;

    logic w_en;
    logic r_ov;

    // whole pipe advances unless the result register is full and held
    assign w_en       = !r_ov || o_out.ready;
    assign i_in.ready = w_en;

    // up vector registers
    logic [CFG_DATA_W-1:0] r_up_x, r_up_y, r_up_z;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_up_x <= UP_X_RST;
            r_up_y <= UP_Y_RST;
            r_up_z <= UP_Z_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_UP_X: r_up_x <= i_cfg.data;
                CFG_UP_Y: r_up_y <= i_cfg.data;
                CFG_UP_Z: r_up_z <= i_cfg.data;
                default:  ;
            endcase
        end
    end

    // stage a: eye minus aim
    logic                       r_av;
    logic [2:0][DIFF_W-1:0]     r_ad;
    t_pos                       r_aeye;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_av <= 1'b0;
        end else if (w_en) begin
            r_av <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ad[0]   <= DIFF_W'(i_in.eye_x) - DIFF_W'(i_in.aim_x);
            r_ad[1]   <= DIFF_W'(i_in.eye_y) - DIFF_W'(i_in.aim_y);
            r_ad[2]   <= DIFF_W'(i_in.eye_z) - DIFF_W'(i_in.aim_z);
            r_aeye[0] <= i_in.eye_x;
            r_aeye[1] <= i_in.eye_y;
            r_aeye[2] <= i_in.eye_z;
        end
    end

    // forward axis
    logic  w_fv;
    t_axis w_fwd;
    t_pos  w_feye;

    lkv_norm #(.IN_W(DIFF_W), .SIDE_W($bits(t_pos))) u_norm_fwd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_av),
        .i_vec   (r_ad),
        .i_side  (r_aeye),
        .o_valid (w_fv),
        .o_axis  (w_fwd),
        .o_side  (w_feye)
    );

    // stage b: up cross forward
    logic                    r_bv;
    logic [2:0][CROSS_W-1:0] r_bc;
    t_pos                    r_beye;
    t_axis                   r_bfwd;
    logic signed [PROD_W-1:0] w_bp [0:5];

    always_comb begin
        w_bp[0] = $signed(r_up_y) * $signed(w_fwd[2]);
        w_bp[1] = $signed(r_up_z) * $signed(w_fwd[1]);
        w_bp[2] = $signed(r_up_z) * $signed(w_fwd[0]);
        w_bp[3] = $signed(r_up_x) * $signed(w_fwd[2]);
        w_bp[4] = $signed(r_up_x) * $signed(w_fwd[1]);
        w_bp[5] = $signed(r_up_y) * $signed(w_fwd[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bv <= 1'b0;
        end else if (w_en) begin
            r_bv <= w_fv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_bc[0] <= CROSS_W'(w_bp[0]) - CROSS_W'(w_bp[1]);
            r_bc[1] <= CROSS_W'(w_bp[2]) - CROSS_W'(w_bp[3]);
            r_bc[2] <= CROSS_W'(w_bp[4]) - CROSS_W'(w_bp[5]);
            r_beye  <= w_feye;
            r_bfwd  <= w_fwd;
        end
    end

    // left axis
    logic  w_lv;
    t_axis w_left;
    t_pos  w_leye;
    t_axis w_lfwd;

    lkv_norm #(.IN_W(CROSS_W), .SIDE_W($bits(t_pos) + $bits(t_axis))) u_norm_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_bv),
        .i_vec   (r_bc),
        .i_side  ({r_beye, r_bfwd}),
        .o_valid (w_lv),
        .o_axis  (w_left),
        .o_side  ({w_leye, w_lfwd})
    );

    // stage c: forward cross left
    logic                    r_cv;
    logic [2:0][CROSS_W-1:0] r_cc;
    t_pos                    r_ceye;
    t_axis                   r_cfwd;
    t_axis                   r_cleft;
    logic signed [PROD_W-1:0] w_cp [0:5];

    always_comb begin
        w_cp[0] = $signed(w_lfwd[1]) * $signed(w_left[2]);
        w_cp[1] = $signed(w_lfwd[2]) * $signed(w_left[1]);
        w_cp[2] = $signed(w_lfwd[2]) * $signed(w_left[0]);
        w_cp[3] = $signed(w_lfwd[0]) * $signed(w_left[2]);
        w_cp[4] = $signed(w_lfwd[0]) * $signed(w_left[1]);
        w_cp[5] = $signed(w_lfwd[1]) * $signed(w_left[0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv <= 1'b0;
        end else if (w_en) begin
            r_cv <= w_lv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_cc[0] <= CROSS_W'(w_cp[0]) - CROSS_W'(w_cp[1]);
            r_cc[1] <= CROSS_W'(w_cp[2]) - CROSS_W'(w_cp[3]);
            r_cc[2] <= CROSS_W'(w_cp[4]) - CROSS_W'(w_cp[5]);
            r_ceye  <= w_leye;
            r_cfwd  <= w_lfwd;
            r_cleft <= w_left;
        end
    end

    // true up axis
    logic  w_tv;
    t_axis w_tup;
    t_pos  w_teye;
    t_axis w_tfwd;
    t_axis w_tleft;

    lkv_norm #(.IN_W(CROSS_W), .SIDE_W($bits(t_pos) + 2 * $bits(t_axis))) u_norm_up (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r_cv),
        .i_vec   (r_cc),
        .i_side  ({r_ceye, r_cfwd, r_cleft}),
        .o_valid (w_tv),
        .o_axis  (w_tup),
        .o_side  ({w_teye, w_tfwd, w_tleft})
    );

    // stage d: axis times eye products; row 0 left, row 1 true up, row 2 forward
    logic                   r_dv;
    logic signed [DP_W-1:0] r_dp [0:2][0:2];
    t_axis                  r_dax [0:2];
    t_axis                  w_rows [0:2];

    assign w_rows[0] = w_tleft;
    assign w_rows[1] = w_tup;
    assign w_rows[2] = w_tfwd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
        end else if (w_en) begin
            r_dv <= w_tv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                for (int i = 0; i < 3; i++) begin
                    r_dp[k][i] <= $signed(w_rows[k][i]) * $signed(w_teye[i]);
                end
                r_dax[k] <= w_rows[k];
            end
        end
    end

    // stage e: negated dot product plus half an output lsb
    logic                    r_ev;
    logic signed [DOT_W-1:0] r_eu [0:2];
    t_axis                   r_eax [0:2];
    logic signed [DOT_W-1:0] w_es [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_es[k] = DOT_W'(r_dp[k][0]) + DOT_W'(r_dp[k][1]) + DOT_W'(r_dp[k][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ev <= 1'b0;
        end else if (w_en) begin
            r_ev <= r_dv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_eu[k]  <= DOT_W'(RND_HALF) - w_es[k];
                r_eax[k] <= r_dax[k];
            end
        end
    end

    // floor to q16.16 and saturate into the result register
    t_axis                   r_oax [0:2];
    logic [POS_W-1:0]        r_osh [0:2];
    logic signed [DOT_W-1:0] w_fq [0:2];
    logic [POS_W-1:0]        w_sat [0:2];

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            w_fq[k] = r_eu[k] >>> RND_SH;
            if (w_fq[k][DOT_W-1:POS_W-1] != {SAT_W{w_fq[k][POS_W-1]}}) begin
                w_sat[k] = w_fq[k][DOT_W-1] ? {1'b1, {(POS_W-1){1'b0}}}
                                            : {1'b0, {(POS_W-1){1'b1}}};
            end else begin
                w_sat[k] = w_fq[k][POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_en) begin
            r_ov <= r_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_oax[k] <= r_eax[k];
                r_osh[k] <= w_sat[k];
            end
        end
    end

    // result beat
    assign o_out.valid      = r_ov;
    assign o_out.row0_x     = r_oax[0][0];
    assign o_out.row0_y     = r_oax[0][1];
    assign o_out.row0_z     = r_oax[0][2];
    assign o_out.row0_shift = r_osh[0];
    assign o_out.row1_x     = r_oax[1][0];
    assign o_out.row1_y     = r_oax[1][1];
    assign o_out.row1_z     = r_oax[1][2];
    assign o_out.row1_shift = r_osh[1];
    assign o_out.row2_x     = r_oax[2][0];
    assign o_out.row2_y     = r_oax[2][1];
    assign o_out.row2_z     = r_oax[2][2];
    assign o_out.row2_shift = r_osh[2];

    // up vector comes out of reset as (0, 1, 0)
    a_up_reset: assert property (@(posedge i_clk)
        $past(!i_rst_n) && !i_cfg.valid |->
            r_up_x == UP_X_RST && r_up_y == UP_Y_RST && r_up_z == UP_Z_RST)
        else $error("up vector not at reset value");

    // forward components stay within one in q2.14
    a_fwd_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |->
            $signed(o_out.row2_x) <= AXIS_ONE && $signed(o_out.row2_x) >= -AXIS_ONE &&
            $signed(o_out.row2_y) <= AXIS_ONE && $signed(o_out.row2_y) >= -AXIS_ONE &&
            $signed(o_out.row2_z) <= AXIS_ONE && $signed(o_out.row2_z) >= -AXIS_ONE)
        else $error("forward axis out of range");

    // eye on aim gives a zero matrix body and zero translations
    a_degenerate: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && o_out.row2_x == '0 && o_out.row2_y == '0 && o_out.row2_z == '0 |->
            o_out.row0_x == '0 && o_out.row1_y == '0 && o_out.row0_shift == '0 &&
            o_out.row1_shift == '0 && o_out.row2_shift == '0)
        else $error("zero forward axis with non-zero rows");

endmodule

>>> rtl/core/lkv_norm.sv
// lkv_norm: pipelined normaliser of a signed 3-vector to a Q2.14 unit vector
// depends on lkv_pkg; carries an opaque side word alongside each vector
module lkv_norm import lkv_pkg::*; #(
    parameter int IN_W   = 33,
    parameter int SIDE_W = 96
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_en,
    input  logic                   i_valid,
    input  logic [2:0][IN_W-1:0]   i_vec,
    input  logic [SIDE_W-1:0]      i_side,
    output logic                   o_valid,
    output t_axis                  o_axis,
    output logic [SIDE_W-1:0]      o_side
);

    localparam int MW = (IN_W > NRM_W) ? IN_W : NRM_W;

    typedef struct packed {
        logic [2:0][NRM_W-1:0] mag;
        logic [2:0]            neg;
        logic                  zero;
        logic [SIDE_W-1:0]     side;
    } t_carry;

    // magnitude and shift stages
    logic                  r_shv [0:NRM_SH_ST];
    logic [2:0][MW-1:0]    r_shm [0:NRM_SH_ST];
    logic [2:0]            r_shn [0:NRM_SH_ST];
    logic [SIDE_W-1:0]     r_shs [0:NRM_SH_ST];

    logic [2:0][MW-1:0]    n_mag0;
    logic [2:0]            n_neg0;
    logic [IN_W-1:0]       w_abs [0:2];

    // absolute values
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_neg0[i] = i_vec[i][IN_W-1];
            w_abs[i]  = n_neg0[i] ? (~i_vec[i] + 1'b1) : i_vec[i];
            n_mag0[i] = MW'(w_abs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_shv[0] <= 1'b0;
        end else if (i_en) begin
            r_shv[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_shm[0] <= n_mag0;
            r_shn[0] <= n_neg0;
            r_shs[0] <= i_side;
        end
    end

    // one power-of-two shift decision per stage, all lanes by the same amount
    for (genvar s = 0; s < NRM_SH_ST; s++) begin : g_shift
        localparam int K = 1 << (NRM_SH_ST - 1 - s);
        logic [MW-1:0]      w_or;
        logic [2:0][MW-1:0] n_m;

        always_comb begin
            w_or = r_shm[s][0] | r_shm[s][1] | r_shm[s][2];
            n_m  = r_shm[s];
            if ((w_or >> (NRM_W - 1 + K)) != '0) begin
                for (int i = 0; i < 3; i++) n_m[i] = r_shm[s][i] >> K;
            end else if ((w_or >> (NRM_W - K)) == '0) begin
                for (int i = 0; i < 3; i++) n_m[i] = r_shm[s][i] << K;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_shv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_shv[s+1] <= r_shv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_shm[s+1] <= n_m;
                r_shn[s+1] <= r_shn[s];
                r_shs[s+1] <= r_shs[s];
            end
        end
    end

    // squares
    logic                      r_sqv;
    logic [2:0][2*NRM_W-1:0]   r_sq;
    t_carry                    r_sqc;
    t_carry                    n_sqc;

    always_comb begin
        for (int i = 0; i < 3; i++) n_sqc.mag[i] = r_shm[NRM_SH_ST][i][NRM_W-1:0];
        n_sqc.neg  = r_shn[NRM_SH_ST];
        n_sqc.zero = (r_shm[NRM_SH_ST] == '0);
        n_sqc.side = r_shs[NRM_SH_ST];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sqv <= 1'b0;
        end else if (i_en) begin
            r_sqv <= r_shv[NRM_SH_ST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= (2*NRM_W)'(n_sqc.mag[i]) * (2*NRM_W)'(n_sqc.mag[i]);
            end
            r_sqc <= n_sqc;
        end
    end

    // sum of squares feeds the root stages, one trial bit each
    logic              r_rtv [0:ROOT_STEPS];
    logic [ROOT_W-1:0] r_rtn [0:ROOT_STEPS];
    logic [ROOT_W-1:0] r_rtr [0:ROOT_STEPS];
    t_carry            r_rtc [0:ROOT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rtv[0] <= 1'b0;
        end else if (i_en) begin
            r_rtv[0] <= r_sqv;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rtn[0] <= ROOT_W'(r_sq[0]) + ROOT_W'(r_sq[1]) + ROOT_W'(r_sq[2]);
            r_rtr[0] <= '0;
            r_rtc[0] <= r_sqc;
        end
    end

    for (genvar j = 0; j < ROOT_STEPS; j++) begin : g_root
        localparam int B = ROOT_TOP - 2 * j;
        logic [ROOT_W-1:0] w_bit;
        logic [ROOT_W-1:0] w_t;
        logic [ROOT_W-1:0] n_n;
        logic [ROOT_W-1:0] n_r;

        always_comb begin
            w_bit = ROOT_W'(1) << B;
            w_t   = r_rtr[j] + w_bit;
            if (r_rtn[j] >= w_t) begin
                n_n = r_rtn[j] - w_t;
                n_r = (r_rtr[j] >> 1) + w_bit;
            end else begin
                n_n = r_rtn[j];
                n_r = r_rtr[j] >> 1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_rtv[j+1] <= 1'b0;
            end else if (i_en) begin
                r_rtv[j+1] <= r_rtv[j];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rtn[j+1] <= n_n;
                r_rtr[j+1] <= n_r;
                r_rtc[j+1] <= r_rtc[j];
            end
        end
    end

    // division: numerator mag*2^15 + len over 2*len, one quotient bit a stage
    logic                     r_dvv [0:QUO_W];
    logic [2:0][DIV_W-1:0]    r_dvn [0:QUO_W];
    logic [2:0][QUO_W-1:0]    r_dvq [0:QUO_W];
    logic [DIV_W-1:0]         r_dvd [0:QUO_W];
    t_carry                   r_dvc [0:QUO_W];
    logic [LEN_W-1:0]         w_len;

    assign w_len = r_rtr[ROOT_STEPS][LEN_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dvv[0] <= 1'b0;
        end else if (i_en) begin
            r_dvv[0] <= r_rtv[ROOT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_dvn[0][i] <= (DIV_W'(r_rtc[ROOT_STEPS].mag[i]) << FRAC_SH)
                               + DIV_W'(w_len);
            end
            r_dvq[0] <= '0;
            r_dvd[0] <= DIV_W'(w_len) << 1;
            r_dvc[0] <= r_rtc[ROOT_STEPS];
        end
    end

    for (genvar s = 0; s < QUO_W; s++) begin : g_div
        localparam int QB = QUO_W - 1 - s;
        logic [DIV_W-1:0]      w_ds;
        logic [2:0][DIV_W-1:0] n_n;
        logic [2:0][QUO_W-1:0] n_q;

        always_comb begin
            w_ds = r_dvd[s] << QB;
            n_n  = r_dvn[s];
            n_q  = r_dvq[s];
            for (int i = 0; i < 3; i++) begin
                if (r_dvn[s][i] >= w_ds) begin
                    n_n[i]     = r_dvn[s][i] - w_ds;
                    n_q[i][QB] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_dvv[s+1] <= 1'b0;
            end else if (i_en) begin
                r_dvv[s+1] <= r_dvv[s];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dvn[s+1] <= n_n;
                r_dvq[s+1] <= n_q;
                r_dvd[s+1] <= r_dvd[s];
                r_dvc[s+1] <= r_dvc[s];
            end
        end
    end

    // clamp, sign and zero vector
    logic              r_ov;
    t_axis             r_axis;
    logic [SIDE_W-1:0] r_side;
    t_axis             n_axis;
    logic [AXIS_W-1:0] w_q [0:2];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_q[i] = AXIS_W'(r_dvq[QUO_W][i]);
            if (w_q[i] > AXIS_W'(AXIS_ONE)) w_q[i] = AXIS_W'(AXIS_ONE);
            if (r_dvc[QUO_W].zero) begin
                n_axis[i] = '0;
            end else if (r_dvc[QUO_W].neg[i]) begin
                n_axis[i] = ~w_q[i] + 1'b1;
            end else begin
                n_axis[i] = w_q[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (i_en) begin
            r_ov <= r_dvv[QUO_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_axis <= n_axis;
            r_side <= r_dvc[QUO_W].side;
        end
    end

    assign o_valid = r_ov;
    assign o_axis  = r_axis;
    assign o_side  = r_side;

endmodule

>>> tb/sv/tb_top.sv
// tb_top: self-checking bench for the look-at view matrix block
// depends on lkv_pkg, the channel interfaces in lkv_ifs and look_at_view_matrix
module tb_top;
    import lkv_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;  // index past the register map
    localparam int N_PHASE     = 8;
    localparam int RAND_ITEMS  = 180;
    localparam int HOLD_CYCLES = 400;  // well beyond the pipeline depth
    localparam int MAX_REPORT  = 10;

    typedef struct packed {
        logic [2:0][POS_W-1:0] eye;
        logic [2:0][POS_W-1:0] aim;
    } t_pose;

    typedef struct packed {
        logic [2:0][AXIS_W-1:0] ax;
        logic [POS_W-1:0]       sh;
    } t_row;

    typedef t_row [2:0] t_view;

    typedef struct packed {
        t_pose pose;
        logic  typed;
        t_view view;
    } t_stim;

    logic i_clk;
    logic i_rst_n;

    lkv_in_if  in_ch ();
    lkv_cfg_if cfg_ch ();
    lkv_out_if out_ch ();

    look_at_view_matrix u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .i_cfg   (cfg_ch),
        .o_out   (out_ch)
    );

    // up vector as the block should hold it
    longint up_now [3];

    t_view  view_q [$];
    t_stim  stim_tab [$];
    int     n_sent;
    int     n_checked;
    int     n_bad;
    bit     idle_on;
    bit     hold_req;

    // clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // view matrix predictor

    function automatic longint unsigned root64(longint unsigned n);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    // unit vector in Q2.14; zero stays zero
    function automatic void unit3(input longint v [3], output longint o [3]);
        longint unsigned mag [3];
        longint unsigned m;
        longint unsigned n2;
        longint unsigned len;
        longint unsigned q;
        bit              neg [3];
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = v[i] < 0;
            mag[i] = neg[i] ? 64'd0 - longint'(v[i]) : v[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) begin
            for (int i = 0; i < 3; i++) o[i] = 0;
            return;
        end
        while (m >= (64'd1 << NRM_W)) begin
            m >>= 1;
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
        end
        while (m < (64'd1 << (NRM_W - 1))) begin
            m <<= 1;
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
        end
        n2  = mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2];
        len = root64(n2);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC_SH) + len) / (2 * len);
            if (q > AXIS_ONE) q = AXIS_ONE;
            o[i] = neg[i] ? -longint'(q) : longint'(q);
        end
    endfunction

    function automatic void cross3(input longint a [3], input longint b [3],
                                   output longint r [3]);
        r[0] = a[1] * b[2] - a[2] * b[1];
        r[1] = a[2] * b[0] - a[0] * b[2];
        r[2] = a[0] * b[1] - a[1] * b[0];
    endfunction

    // axis plus minus its dot with the eye, rounded half up and saturated
    function automatic t_row axis_row(input longint a [3], input longint eye [3]);
        t_row   r;
        longint t;
        longint q;
        t = -(a[0] * eye[0] + a[1] * eye[1] + a[2] * eye[2]);
        q = (t + RND_HALF) >>> RND_SH;
        if (q > 64'sd2147483647) q = 64'sd2147483647;
        if (q < -64'sd2147483648) q = -64'sd2147483648;
        for (int j = 0; j < 3; j++) r.ax[j] = a[j][AXIS_W-1:0];
        r.sh = q[POS_W-1:0];
        return r;
    endfunction

    function automatic t_view predict_view(input t_pose p);
        longint eye [3];
        longint d [3];
        longint c [3];
        longint fwd [3];
        longint lft [3];
        longint tup [3];
        t_view  v;
        for (int i = 0; i < 3; i++) begin
            eye[i] = longint'($signed(p.eye[i]));
            d[i]   = eye[i] - longint'($signed(p.aim[i]));
        end
        unit3(d, fwd);
        cross3(up_now, fwd, c);
        unit3(c, lft);
        cross3(fwd, lft, c);
        unit3(c, tup);
        v[0] = axis_row(lft, eye);
        v[1] = axis_row(tup, eye);
        v[2] = axis_row(fwd, eye);
        return v;
    endfunction

    // ------------------------------------------------------------------
    // stimulus helpers

    function automatic t_pose mk_pose(input int ex, ey, ez, ax, ay, az);
        t_pose p;
        p.eye[0] = ex; p.eye[1] = ey; p.eye[2] = ez;
        p.aim[0] = ax; p.aim[1] = ay; p.aim[2] = az;
        return p;
    endfunction

    function automatic t_row mk_row(input int x, y, z, s);
        t_row r;
        r.ax[0] = x[AXIS_W-1:0];
        r.ax[1] = y[AXIS_W-1:0];
        r.ax[2] = z[AXIS_W-1:0];
        r.sh    = s;
        return r;
    endfunction

    task automatic add_row(input t_pose p, input bit typed, input t_view v);
        t_stim s;
        s.pose  = p;
        s.typed = typed;
        s.view  = v;
        stim_tab.push_back(s);
    endtask

    function automatic int rand_coord();
        return $signed($urandom) >>> $urandom_range(0, 28);
    endfunction

    // mostly general poses, with degenerate and near-degenerate ones mixed in
    function automatic t_pose rand_pose();
        t_pose p;
        int    k;
        int    mode;
        mode = $urandom_range(0, 9);
        for (int i = 0; i < 3; i++) begin
            p.eye[i] = (mode < 4) ? $urandom : rand_coord();
            p.aim[i] = (mode < 4) ? $urandom : rand_coord();
        end
        case (mode)
            7: begin
                p.aim = p.eye;
            end
            8: begin
                k = $urandom_range(1, 64);
                for (int i = 0; i < 3; i++) p.aim[i] = p.eye[i] - int'(up_now[i]) * k;
            end
            9: begin
                k = $urandom_range(0, 2);
                p.aim = p.eye;
                p.aim[k] = rand_coord();
            end
            default: ;
        endcase
        return p;
    endfunction

    // ------------------------------------------------------------------
    // channel drivers

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
        @(posedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= val[CFG_DATA_W-1:0];
        do @(posedge i_clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        if (idx != CFG_UNUSED) up_now[idx] = longint'($signed(val[CFG_DATA_W-1:0]));
    endtask

    task automatic set_up(input int x, y, z);
        write_reg(CFG_UP_X, x);
        write_reg(CFG_UP_Y, y);
        write_reg(CFG_UP_Z, z);
    endtask

    // called at a rising edge; returns at the edge that took the beat, or after a random idle gap that follows it
    task automatic send_pose(input t_pose p, input bit typed, input t_view v);
        in_ch.valid <= 1'b1;
        in_ch.eye_x <= p.eye[0];
        in_ch.eye_y <= p.eye[1];
        in_ch.eye_z <= p.eye[2];
        in_ch.aim_x <= p.aim[0];
        in_ch.aim_y <= p.aim[1];
        in_ch.aim_z <= p.aim[2];
        do @(posedge i_clk); while (!in_ch.ready);
        view_q.push_back(typed ? v : predict_view(p));
        n_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge i_clk);
        end
    endtask

    // ------------------------------------------------------------------
    // result side: checks each beat, stalls at random, long hold on request

    initial begin
        int hold_cnt;
        int stall_cnt;
        t_view want;
        t_view got;
        hold_cnt  = 0;
        stall_cnt = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (out_ch.valid && out_ch.ready) begin
                got[0] = mk_row(out_ch.row0_x, out_ch.row0_y, out_ch.row0_z, out_ch.row0_shift);
                got[1] = mk_row(out_ch.row1_x, out_ch.row1_y, out_ch.row1_z, out_ch.row1_shift);
                got[2] = mk_row(out_ch.row2_x, out_ch.row2_y, out_ch.row2_z, out_ch.row2_shift);
                if (view_q.size() == 0) begin
                    n_bad++;
                    if (n_bad <= MAX_REPORT) $display("unexpected result beat: %h", got);
                end else begin
                    want = view_q.pop_front();
                    n_checked++;
                    for (int r = 0; r < 3; r++) begin
                        if (got[r] !== want[r]) begin
                            n_bad++;
                            if (n_bad <= MAX_REPORT)
                                $display("result %0d row %0d: exp %0d %0d %0d %0d got %0d %0d %0d %0d",
                                    n_checked, r,
                                    $signed(want[r].ax[0]), $signed(want[r].ax[1]),
                                    $signed(want[r].ax[2]), $signed(want[r].sh),
                                    $signed(got[r].ax[0]), $signed(got[r].ax[1]),
                                    $signed(got[r].ax[2]), $signed(got[r].sh));
                        end
                    end
                end
            end
            if (hold_req) begin
                hold_req  = 1'b0;
                hold_cnt  = HOLD_CYCLES;
            end
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_cnt > 0) begin
                hold_cnt--;
                out_ch.ready <= 1'b0;
            end else if (stall_cnt > 0) begin
                stall_cnt--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                stall_cnt = $urandom_range(0, 17);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // main sequence

    initial begin
        t_view zero_view;
        t_view v;
        int    n_typed;
        zero_view = '0;
        n_sent    = 0;
        n_checked = 0;
        n_bad     = 0;
        n_typed   = 0;
        idle_on   = 1'b1;
        hold_req  = 1'b0;
        up_now[0] = 0;
        up_now[1] = AXIS_ONE;
        up_now[2] = 0;

        i_rst_n      <= 1'b0;
        in_ch.valid  <= 1'b0;
        in_ch.eye_x  <= '0;
        in_ch.eye_y  <= '0;
        in_ch.eye_z  <= '0;
        in_ch.aim_x  <= '0;
        in_ch.aim_y  <= '0;
        in_ch.aim_z  <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.index <= CFG_UP_X;
        cfg_ch.data  <= '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed table, default up vector
        add_row(mk_pose(0, 0, 0, 0, 0, 0), 1'b1, zero_view);
        add_row(mk_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b1, zero_view);
        add_row(mk_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h80000000, 32'h80000000, 32'h80000000), 1'b1, zero_view);
        v[0] = mk_row(AXIS_ONE, 0, 0, 0);
        v[1] = mk_row(0, AXIS_ONE, 0, 0);
        v[2] = mk_row(0, 0, AXIS_ONE, -65536);
        add_row(mk_pose(0, 0, 65536, 0, 0, 0), 1'b1, v);
        // looking along up: only the forward row survives
        v[0] = mk_row(0, 0, 0, 0);
        v[1] = mk_row(0, 0, 0, 0);
        v[2] = mk_row(0, AXIS_ONE, 0, -327680);
        add_row(mk_pose(0, 5 * 65536, 0, 0, 0, 0), 1'b1, v);
        v[2] = mk_row(0, -AXIS_ONE, 0, -65536);
        add_row(mk_pose(0, -65536, 0, 0, 0, 0), 1'b1, v);
        // smallest offset along x
        v[0] = mk_row(0, 0, -AXIS_ONE, 0);
        v[1] = mk_row(0, AXIS_ONE, 0, 0);
        v[2] = mk_row(AXIS_ONE, 0, 0, -1);
        add_row(mk_pose(1, 0, 0, 0, 0, 0), 1'b1, v);
        // extremes and saturation of the translation
        add_row(mk_pose(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
                        32'h80000000, 32'h80000000, 32'h80000000), 1'b0, zero_view);
        add_row(mk_pose(32'h80000000, 32'h80000000, 32'h80000000,
                        32'h7fffffff, 32'h7fffffff, 32'h7fffffff), 1'b0, zero_view);
        add_row(mk_pose(32'h7fffffff, 0, 0, 32'h80000000, 0, 0), 1'b0, zero_view);
        add_row(mk_pose(0, 0, 32'h80000000, 0, 0, 32'h7fffffff), 1'b0, zero_view);
        add_row(mk_pose(3 * 65536, 4 * 65536, 0, 0, 0, 0), 1'b0, zero_view);
        add_row(mk_pose(32'h55555555, 32'haaaaaaaa, 32'h55555555,
                        32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa), 1'b0, zero_view);
        add_row(mk_pose(32'haaaaaaaa, 32'h55555555, 32'haaaaaaaa,
                        32'h55555555, 32'haaaaaaaa, 32'h55555555), 1'b0, zero_view);

        for (int ph = 0; ph < N_PHASE; ph++) begin
            case (ph)
                1: set_up(0, -AXIS_ONE, 0);
                2: set_up(AXIS_ONE, 0, 0);
                3: begin
                    set_up(0, 0, AXIS_ONE);
                    write_reg(CFG_UNUSED, 16'h1234);
                end
                4: set_up(AXIS_ONE, AXIS_ONE, -AXIS_ONE);
                5: set_up(0, 0, 0);
                6: set_up(32767, -32768, 1);
                7: set_up($urandom_range(0, 2 * AXIS_ONE) - AXIS_ONE,
                          $urandom_range(0, 2 * AXIS_ONE) - AXIS_ONE,
                          $urandom_range(0, 2 * AXIS_ONE) - AXIS_ONE);
                default: ;
            endcase
            idle_on = (ph != N_PHASE - 1);
            @(posedge i_clk);
            if (ph == 0) begin
                foreach (stim_tab[i]) begin
                    send_pose(stim_tab[i].pose, stim_tab[i].typed, stim_tab[i].view);
                    if (stim_tab[i].typed) n_typed++;
                end
            end
            if (ph == 2) hold_req = 1'b1;
            for (int i = 0; i < RAND_ITEMS; i++) send_pose(rand_pose(), 1'b0, zero_view);
            in_ch.valid <= 1'b0;
            wait (view_q.size() == 0);
        end

        repeat (200) @(posedge i_clk);
        $display("%0d poses sent over %0d up-vector settings, %0d results checked",
                 n_sent, N_PHASE, n_checked);
        $display("%0d directed rows with fixed results, %0d mismatches", n_typed, n_bad);
        if (n_bad == 0 && view_q.size() == 0) begin
            $display("[look_at_view_matrix] OK");
        end else begin
            $display("[look_at_view_matrix] ERROR");
        end
        $finish;
    end

    // timeout
    initial begin
        #20_000_000;
        $display("[look_at_view_matrix] ERROR");
        $finish;
    end

endmodule

>>> filelist.f
rtl/core/lkv_pkg.sv
rtl/core/lkv_ifs.sv
rtl/core/lkv_norm.sv
rtl/core/look_at_view_matrix.sv
tb/sv/tb_top.sv
